FILE: hw/rtl/lisl_pkg.sv
`default_nettype none

package lisl_pkg;

    localparam int MAX_ELEMENTS_DEF = 256;
    localparam int VALUE_WIDTH_DEF  = 32;

    // flags that ride along with each word through the cell row
    typedef struct packed {
        logic valid;
        logic start;
    } t_tok_ctl;

endpackage

`default_nettype wire

FILE: hw/rtl/lisl_cell.sv
`default_nettype none

module lisl_cell #(
    parameter int VALUE_WIDTH = lisl_pkg::VALUE_WIDTH_DEF,
    parameter int LEN_WIDTH   = 9,
    parameter int CELL_IDX    = 0
) (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           i_adv,
    input  wire lisl_pkg::t_tok_ctl       i_ctl,
    input  wire signed [VALUE_WIDTH-1:0]  i_key,
    input  wire        [LEN_WIDTH-1:0]    i_idx,
    input  wire        [LEN_WIDTH-1:0]    i_best,
    output lisl_pkg::t_tok_ctl            o_ctl,
    output logic signed [VALUE_WIDTH-1:0] o_key,
    output logic       [LEN_WIDTH-1:0]    o_idx,
    output logic       [LEN_WIDTH-1:0]    o_best
);

    localparam logic [LEN_WIDTH-1:0] MY_IDX = LEN_WIDTH'(CELL_IDX);

    // stored element and the length ending at it
    logic signed [VALUE_WIDTH-1:0] r_val;
    logic        [LEN_WIDTH-1:0]   r_len;

    lisl_pkg::t_tok_ctl            r_ctl;
    logic signed [VALUE_WIDTH-1:0] r_key;
    logic        [LEN_WIDTH-1:0]   r_idx;
    logic        [LEN_WIDTH-1:0]   r_best;

    logic                  w_hit;
    logic                  w_store;
    logic [LEN_WIDTH-1:0]  n_best;

    always_comb begin
        // only entries below the word's own slot belong to its sequence
        w_hit   = i_ctl.valid && (MY_IDX < i_idx) && (r_val < i_key) && (r_len > i_best);
        n_best  = w_hit ? r_len : i_best;
        // every earlier entry has been seen by the time the word reaches its slot
        w_store = i_ctl.valid && (i_idx == MY_IDX);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (i_adv) begin
            r_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_key  <= i_key;
            r_idx  <= i_idx;
            r_best <= n_best;
            if (w_store) begin
                r_val <= i_key;
                r_len <= i_best + LEN_WIDTH'(1);
            end
        end
    end

    assign o_ctl  = r_ctl;
    assign o_key  = r_key;
    assign o_idx  = r_idx;
    assign o_best = r_best;

endmodule

`default_nettype wire

FILE: hw/rtl/longest_increasing_subsequence_len.sv
// Longest strictly increasing subsequence length, streaming.
// Slave channel: one element per word, tdata holds the signed element,
// tuser is the start flag that opens a new sequence (history dropped).
// Master channel: one result word per element, tdata holds the length
// ending at that element and the best length of the sequence so far,
// tuser is the sticky overflow flag for the current sequence.
// Elements travel down a row of MAX_ELEMENTS cells, one cell per cycle
// while the row advances; cell k holds the k-th stored element of the
// sequence. A result reaches the master side through every cell register
// and then the output register; a new element can be taken every cycle
// unless the row is frozen, so throughput is one word per cycle.
// Reset clears all valid flags, the element count, the best length and
// the overflow flag; the first element after reset opens a sequence.
// When the master side stalls with a result held, the whole row freezes
// and tready drops only once a word has reached the end of the row.
// Elements past MAX_ELEMENTS in a sequence are not stored and set overflow.
`default_nettype none

module longest_increasing_subsequence_len #(
    parameter int MAX_ELEMENTS = lisl_pkg::MAX_ELEMENTS_DEF,
    parameter int VALUE_WIDTH  = lisl_pkg::VALUE_WIDTH_DEF,
    localparam int LEN_WIDTH   = $clog2(MAX_ELEMENTS + 1),
    localparam int IN_TW       = ((VALUE_WIDTH + 7) / 8) * 8,
    localparam int OUT_TW      = ((2 * LEN_WIDTH + 7) / 8) * 8
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_s_axis_tvalid,
    output logic                o_s_axis_tready,
    input  wire  [IN_TW-1:0]    i_s_axis_tdata,   // element_value
    input  wire                 i_s_axis_tuser,   // start_req
    output logic                o_m_axis_tvalid,
    input  wire                 i_m_axis_tready,
    output logic [OUT_TW-1:0]   o_m_axis_tdata,   // length_ending_here, best_length
    output logic                o_m_axis_tuser    // overflow
);

    localparam logic [LEN_WIDTH-1:0] CAP = LEN_WIDTH'(MAX_ELEMENTS);

    lisl_pkg::t_tok_ctl            w_ctl  [0:MAX_ELEMENTS];
    logic signed [VALUE_WIDTH-1:0] w_key  [0:MAX_ELEMENTS];
    logic        [LEN_WIDTH-1:0]   w_idx  [0:MAX_ELEMENTS];
    logic        [LEN_WIDTH-1:0]   w_best [0:MAX_ELEMENTS];

    logic                 w_adv;
    logic                 w_accept;
    logic [LEN_WIDTH-1:0] r_count;
    logic [LEN_WIDTH-1:0] n_count;

    logic                 r_out_valid;
    logic [LEN_WIDTH-1:0] r_out_len;
    logic [LEN_WIDTH-1:0] r_out_best;
    logic                 r_out_ovf;
    logic [LEN_WIDTH-1:0] r_best;
    logic                 r_ovf;

    logic [LEN_WIDTH:0]   w_len_ext;
    logic [LEN_WIDTH-1:0] w_len;
    logic                 w_ovf;
    logic [LEN_WIDTH-1:0] n_best;
    logic                 n_ovf;

    // the row only has to stop when a finished word cannot leave it
    assign w_adv           = !w_ctl[MAX_ELEMENTS].valid || !r_out_valid || i_m_axis_tready;
    assign o_s_axis_tready = w_adv;
    assign w_accept        = i_s_axis_tvalid && w_adv;

    assign w_ctl[0].valid = w_accept;
    assign w_ctl[0].start = i_s_axis_tuser;
    assign w_key[0]       = $signed(i_s_axis_tdata[VALUE_WIDTH-1:0]);
    assign w_idx[0]       = i_s_axis_tuser ? '0 : r_count;
    assign w_best[0]      = '0;
    assign n_count        = (w_idx[0] < CAP) ? w_idx[0] + LEN_WIDTH'(1) : w_idx[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (w_accept) begin
            r_count <= n_count;
        end
    end

    for (genvar g = 0; g < MAX_ELEMENTS; g++) begin : g_cell
        lisl_cell #(
            .VALUE_WIDTH (VALUE_WIDTH),
            .LEN_WIDTH   (LEN_WIDTH),
            .CELL_IDX    (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (w_adv),
            .i_ctl   (w_ctl[g]),
            .i_key   (w_key[g]),
            .i_idx   (w_idx[g]),
            .i_best  (w_best[g]),
            .o_ctl   (w_ctl[g+1]),
            .o_key   (w_key[g+1]),
            .o_idx   (w_idx[g+1]),
            .o_best  (w_best[g+1])
        );
    end

    always_comb begin
        w_len_ext = {1'b0, w_best[MAX_ELEMENTS]} + (LEN_WIDTH + 1)'(1);
        w_len     = (w_len_ext > {1'b0, CAP}) ? CAP : w_len_ext[LEN_WIDTH-1:0];
        // a word that found no free slot was not stored
        w_ovf     = (w_idx[MAX_ELEMENTS] == CAP);
        if (w_ctl[MAX_ELEMENTS].start) begin
            n_best = w_len;
            n_ovf  = w_ovf;
        end else begin
            n_best = (w_len > r_best) ? w_len : r_best;
            n_ovf  = r_ovf || w_ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_best      <= '0;
            r_ovf       <= 1'b0;
        end else begin
            // a held result word stays until the master side takes it
            if (!r_out_valid || i_m_axis_tready) begin
                r_out_valid <= w_ctl[MAX_ELEMENTS].valid;
            end
            if (w_adv && w_ctl[MAX_ELEMENTS].valid) begin
                r_best <= n_best;
                r_ovf  <= n_ovf;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && w_ctl[MAX_ELEMENTS].valid) begin
            r_out_len  <= w_len;
            r_out_best <= n_best;
            r_out_ovf  <= n_ovf;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = OUT_TW'({r_out_best, r_out_len});
    assign o_m_axis_tuser  = r_out_ovf;

    a_len_within_best: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_len <= r_out_best))
        else $error("length exceeds best length");

    a_len_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_len != '0))
        else $error("zero length result");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CAP)
        else $error("element count beyond capacity");

    a_ovf_at_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && !i_s_axis_tuser && (r_count == CAP)) |=> (r_count == CAP))
        else $error("count moved past a full store");

endmodule

`default_nettype wire
